// File: rtl/rmt_pkg.sv
`default_nettype none
package rmt_pkg;

  localparam int NUM_KEYS   = 1024;
  localparam int VALUE_BITS = 32;

  localparam int POS_W   = 11;
  localparam int IN_VAL_W = 32;
  localparam int OUT_W   = 32;

  localparam int TREE_NODES = 2 * NUM_KEYS;
  localparam int NODE_AW    = $clog2(TREE_NODES);
  localparam int LR_W       = ((NODE_AW > POS_W) ? NODE_AW : POS_W) + 1;

  localparam logic CMD_RAISE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic upd_step;
    logic qry_step;
    logic out_load;
  } rmt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic pos_ok;
    logic upd_last;
    logic qry_done;
  } rmt_stat_t;

endpackage
`default_nettype wire

// File: rtl/rmt_datapath.sv
`default_nettype none
module rmt_datapath
  import rmt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rmt_cmd_t            cmd,
  output rmt_stat_t                stat,
  input  wire logic                in_command,
  input  wire logic [POS_W-1:0]    in_position,
  input  wire logic [IN_VAL_W-1:0] in_new_value,
  input  wire logic [POS_W-1:0]    in_range_low,
  input  wire logic [POS_W-1:0]    in_range_high,
  output logic [OUT_W-1:0]         out_range_maximum
);

  logic [VALUE_BITS-1:0] mem [TREE_NODES];

  logic [VALUE_BITS-1:0] rd_a_q, rd_b_q;
  logic [NODE_AW-1:0]    rd_a_addr, rd_b_addr;
  logic                  wr_en;
  logic [NODE_AW-1:0]    wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic [NODE_AW-1:0]    clr_cnt_r;
  logic [NODE_AW-1:0]    upd_idx_r;
  logic [NODE_AW-1:0]    upd_wr_addr_r;
  logic                  upd_pend_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [LR_W-1:0]       l_r, r_r;
  logic                  take_a_r, take_b_r;
  logic [VALUE_BITS-1:0] best_r;
  logic [OUT_W-1:0]      out_data_r;

  logic [LR_W-1:0]       lo_c, hi_w, hi_c, l_init, r_init, r_m1;
  logic [NODE_AW-1:0]    leaf;
  logic                  active;
  logic [VALUE_BITS-1:0] cand_a, cand_b, best_ab, best_nxt, upd_max;

  assign lo_c   = (in_range_low == '0) ? LR_W'(1) : LR_W'(in_range_low);
  assign hi_w   = LR_W'(in_range_high);
  assign hi_c   = (hi_w > LR_W'(NUM_KEYS)) ? LR_W'(NUM_KEYS) : hi_w;
  assign l_init = LR_W'(NUM_KEYS - 1) + lo_c;
  assign r_init = LR_W'(NUM_KEYS) + hi_c;
  assign leaf   = NODE_AW'(NUM_KEYS - 1) + NODE_AW'(in_position);

  assign active = l_r < r_r;
  assign r_m1   = r_r - LR_W'(1);

  assign cand_a   = take_a_r ? rd_a_q : '0;
  assign cand_b   = take_b_r ? rd_b_q : '0;
  assign best_ab  = (cand_a > cand_b) ? cand_a : cand_b;
  assign best_nxt = (best_ab > best_r) ? best_ab : best_r;
  assign upd_max  = (rd_a_q > val_r) ? rd_a_q : val_r;

  assign rd_a_addr = cmd.upd_step ? upd_idx_r : l_r[NODE_AW-1:0];
  assign rd_b_addr = r_m1[NODE_AW-1:0];

  assign wr_en   = cmd.clr_step | (cmd.upd_step & upd_pend_r);
  assign wr_addr = cmd.clr_step ? clr_cnt_r : upd_wr_addr_r;
  assign wr_data = cmd.clr_step ? '0 : upd_max;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      upd_pend_r <= 1'b0;
      take_a_r   <= 1'b0;
      take_b_r   <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + NODE_AW'(1);
      end
      if (cmd.load) begin
        upd_pend_r <= 1'b0;
        take_a_r   <= 1'b0;
        take_b_r   <= 1'b0;
      end else begin
        if (cmd.upd_step) begin
          upd_pend_r <= 1'b1;
        end
        if (cmd.qry_step) begin
          take_a_r <= active & l_r[0];
          take_b_r <= active & r_r[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upd_idx_r <= leaf;
      val_r     <= VALUE_BITS'(in_new_value);
      l_r       <= l_init;
      r_r       <= r_init;
      best_r    <= '0;
    end else begin
      if (cmd.upd_step) begin
        upd_idx_r     <= upd_idx_r >> 1;
        upd_wr_addr_r <= upd_idx_r;
      end
      if (cmd.qry_step) begin
        best_r <= best_nxt;
        if (active) begin
          l_r <= (l_r + LR_W'(l_r[0])) >> 1;
          r_r <= r_r >> 1;
        end
      end
    end
    if (cmd.out_load) begin
      out_data_r <= OUT_W'(best_r);
    end
  end

  assign stat.clr_last = (clr_cnt_r == NODE_AW'(TREE_NODES - 1));
  assign stat.is_query = (in_command == CMD_QUERY);
  assign stat.pos_ok   = (in_position != '0) && (LR_W'(in_position) <= LR_W'(NUM_KEYS));
  assign stat.upd_last = (upd_idx_r == '0);
  assign stat.qry_done = !active && !take_a_r && !take_b_r;

  assign out_range_maximum = out_data_r;

  a_take_needs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.qry_step && !cmd.load && !active) |=> (!take_a_r && !take_b_r))
    else $error("query read flagged after range closed");

  a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.qry_step && !cmd.load) |=> (best_r >= $past(best_r)))
    else $error("query maximum decreased");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd_step && upd_pend_r) |-> (upd_idx_r != upd_wr_addr_r))
    else $error("update read and write on one node");

endmodule
`default_nettype wire

// File: rtl/rmt_ctrl.sv
`default_nettype none
module rmt_ctrl
  import rmt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire rmt_stat_t stat,
  output rmt_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_QRY,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.is_query) state_nxt = S_QRY;
          else if (stat.pos_ok) state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd_step = 1'b1;
        if (stat.upd_last) state_nxt = S_IDLE;
      end
      S_QRY: begin
        cmd.qry_step = 1'b1;
        if (stat.qry_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == S_IDLE))
    else $error("ready outside idle");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("result overwrote pending output");

  a_upd_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && stat.upd_last) |=> (state_r == S_IDLE))
    else $error("update walk did not end at root");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_ready_r)
    else $error("item loaded while not ready");

endmodule
`default_nettype wire

// File: rtl/range_max_tree_unit.sv
// channel | signals                                           | accepted when
// in      | in_valid in_ready in_command in_position          | in_valid && in_ready
//         | in_new_value in_range_low in_range_high           |
// out     | out_valid out_ready out_range_maximum             | out_valid && out_ready
//
// Update: walks from the leaf up to the root, one tree level per cycle through the node RAM.
// Query: a walk of the tree from both range ends, then the result load; two reads per level.
// Reset: a clearing pass over all 2*NUM_KEYS (2048) nodes zeroes the node RAM; no request taken then.
// A request is taken while a result still waits; a second query holds until out is free.
`default_nettype none
module range_max_tree_unit
  import rmt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_command,
  input  wire logic [POS_W-1:0]    in_position,
  input  wire logic [IN_VAL_W-1:0] in_new_value,
  input  wire logic [POS_W-1:0]    in_range_low,
  input  wire logic [POS_W-1:0]    in_range_high,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OUT_W-1:0]         out_range_maximum
);

  rmt_cmd_t  cmd;
  rmt_stat_t stat;

  rmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rmt_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_new_value      (in_new_value),
    .in_range_low      (in_range_low),
    .in_range_high     (in_range_high),
    .out_range_maximum (out_range_maximum)
  );

endmodule
`default_nettype wire
